// File: hw/rtl/nps_pkg.sv
// Shared types, codes and helpers for the priority scheduler.
package nps_pkg;

  localparam int unsigned DefQueueDepth = 16;

  localparam int unsigned IdW    = 16;
  localparam int unsigned BurstW = 16;
  localparam int unsigned PrioW  = 8;
  localparam int unsigned KindW  = 2;
  localparam int unsigned TimeW  = 20;
  localparam int unsigned SumW   = 24;
  localparam int unsigned DoneW  = 5;

  localparam logic [31:0] TimeMax = 32'h000F_FFFF;
  localparam logic [31:0] SumMax  = 32'h00FF_FFFF;
  localparam logic [31:0] DoneMax = 32'd31;

  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_START = 1'b1;

  typedef enum logic [KindW-1:0] {
    KIND_EXEC    = 2'd0,
    KIND_ADDED   = 2'd1,
    KIND_DROPPED = 2'd2,
    KIND_EMPTY   = 2'd3
  } kind_t;

  typedef struct packed {
    logic [IdW-1:0]    id;
    logic [BurstW-1:0] burst;
    logic [PrioW-1:0]  prio;
  } job_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD_RD,
    S_ADD_CMP,
    S_ADD_WR,
    S_ONE,
    S_DRN_RD,
    S_DRN_CALC,
    S_DRN_EMIT
  } state_t;

  function automatic logic [31:0] sat_u32(input logic [31:0] v, input logic [31:0] lim);
    return (v > lim) ? lim : v;
  endfunction

endpackage

// File: hw/rtl/nps_ifs.sv
// Valid/ready channel interfaces for job items and result items.
interface nps_job_if import nps_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              op;
  logic [IdW-1:0]    job_id;
  logic [BurstW-1:0] burst_ms;
  logic [PrioW-1:0]  prio_level;

  modport source (output valid, op, job_id, burst_ms, prio_level, input ready);
  modport sink   (input valid, op, job_id, burst_ms, prio_level, output ready);
endinterface

interface nps_res_if import nps_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KindW-1:0]  kind;
  logic [IdW-1:0]    out_id;
  logic [BurstW-1:0] out_burst;
  logic [PrioW-1:0]  out_prio;
  logic [TimeW-1:0]  turnaround;
  logic [TimeW-1:0]  waiting;
  logic [SumW-1:0]   sum_turnaround;
  logic [SumW-1:0]   sum_waiting;
  logic [DoneW-1:0]  jobs_done;
  logic              last;

  modport source (output valid, kind, out_id, out_burst, out_prio, turnaround, waiting,
                  sum_turnaround, sum_waiting, jobs_done, last, input ready);
  modport sink   (input valid, kind, out_id, out_burst, out_prio, turnaround, waiting,
                  sum_turnaround, sum_waiting, jobs_done, last, output ready);
endinterface

// File: hw/rtl/nonpreemptive_priority_scheduler_unit.sv
// Non-preemptive priority scheduler: sorted ready queue in RAM, insert and drain sequencer.
// Add: walks the queue from the tail, moving each lower-priority job down a slot, then
//   writes the new job; into an empty queue it is written at once; a full queue drops it.
// Start: per queued job a RAM read, a running-time add, then totals and load; if empty, one result.
// One item at a time; receiver stalls hold the sequencer until the result register is free.
// Reset clears the sequencer, occupancy and the result valid flag; queue RAM is not cleared.
module nonpreemptive_priority_scheduler_unit import nps_pkg::*; #(
  parameter int unsigned QueueDepth = DefQueueDepth
) (
  input logic       clk,
  input logic       rst,
  nps_job_if.sink   jobs,
  nps_res_if.source results
);

  localparam int unsigned AddrW = $clog2(QueueDepth);
  localparam int unsigned CntW  = $clog2(QueueDepth + 1);
  localparam int unsigned TatW  = BurstW + CntW;   // running completion time, no loss
  localparam int unsigned AccW  = TatW + CntW;     // running totals, no loss

  // Queue storage: slot 0 is served first
  job_t mem [QueueDepth];
  job_t rd_data;

  // Sequencer state
  state_t            state;
  state_t            state_next;
  logic [CntW-1:0]   occ;
  logic [AddrW-1:0]  pos;
  logic [AddrW-1:0]  idx;
  job_t              nj;         // job carried by the accepted item
  kind_t             res_kind;   // kind of a single-result item
  job_t              cur;        // job being executed
  logic [TatW-1:0]   tat;
  logic [TatW-1:0]   tat_prev;
  logic [AccW-1:0]   stat;
  logic [AccW-1:0]   swt;

  // Result register
  logic              o_valid;
  kind_t             o_kind;
  job_t              o_job;
  logic [TimeW-1:0]  o_tat;
  logic [TimeW-1:0]  o_wait;
  logic [SumW-1:0]   o_stat;
  logic [SumW-1:0]   o_swt;
  logic [DoneW-1:0]  o_done;
  logic              o_last;

  // Combinational controls
  logic              in_ready;
  logic              in_xfer;
  logic [AddrW-1:0]  raddr;
  logic              we;
  logic [AddrW-1:0]  waddr;
  job_t              wdata;
  logic              emit;
  logic              load;
  logic              shift_down;
  logic              drn_last;
  logic [AccW-1:0]   stat_sum;
  logic [AccW-1:0]   swt_sum;
  logic [31:0]       tat_s;
  logic [31:0]       wait_s;
  logic [31:0]       stat_s;
  logic [31:0]       swt_s;
  logic [31:0]       done_s;
  kind_t             r_kind;
  job_t              r_job;
  logic [TimeW-1:0]  r_tat;
  logic [TimeW-1:0]  r_wait;
  logic [SumW-1:0]   r_stat;
  logic [SumW-1:0]   r_swt;
  logic [DoneW-1:0]  r_done;
  logic              r_last;

  assign in_xfer    = jobs.valid && in_ready;
  // the waiting job moves down while the new one outranks it; ties keep arrival order
  assign shift_down = rd_data.prio < nj.prio;
  assign drn_last   = (CntW'(idx) + CntW'(1)) == occ;
  assign stat_sum   = stat + AccW'(tat);
  assign swt_sum    = swt + AccW'(tat_prev);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_xfer) begin
          if (jobs.op == OP_ADD) begin
            if (occ >= CntW'(QueueDepth)) begin
              state_next = S_ONE;
            end else if (occ == '0) begin
              state_next = S_ADD_WR;
            end else begin
              state_next = S_ADD_RD;
            end
          end else begin
            state_next = (occ == '0) ? S_ONE : S_DRN_RD;
          end
        end
      end
      S_ADD_RD:   state_next = S_ADD_CMP;
      S_ADD_CMP: begin
        if (shift_down && pos != AddrW'(1)) begin
          state_next = S_ADD_RD;
        end else begin
          state_next = S_ADD_WR;
        end
      end
      S_ADD_WR:   state_next = S_ONE;
      S_ONE: begin
        if (load) begin
          state_next = S_IDLE;
        end
      end
      S_DRN_RD:   state_next = S_DRN_CALC;
      S_DRN_CALC: state_next = S_DRN_EMIT;
      S_DRN_EMIT: begin
        if (load) begin
          state_next = drn_last ? S_IDLE : S_DRN_RD;
        end
      end
      default:    state_next = S_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    in_ready = 1'b0;
    raddr    = idx;
    we       = 1'b0;
    waddr    = pos;
    wdata    = nj;
    emit     = 1'b0;
    tat_s    = sat_u32(32'(tat), TimeMax);
    wait_s   = sat_u32(32'(tat_prev), TimeMax);
    stat_s   = sat_u32(32'(stat_sum), SumMax);
    swt_s    = sat_u32(32'(swt_sum), SumMax);
    done_s   = sat_u32(32'(idx) + 32'd1, DoneMax);
    r_kind   = res_kind;
    r_job    = (res_kind == KIND_EMPTY) ? '0 : nj;
    r_tat    = '0;
    r_wait   = '0;
    r_stat   = '0;
    r_swt    = '0;
    r_done   = '0;
    r_last   = 1'b1;
    case (state)
      S_IDLE:   in_ready = 1'b1;
      S_ADD_RD: raddr = pos - AddrW'(1);
      S_ADD_CMP: begin
        if (shift_down) begin
          we    = 1'b1;
          wdata = rd_data;
        end
      end
      S_ADD_WR: we = 1'b1;
      S_ONE:    emit = 1'b1;
      S_DRN_EMIT: begin
        emit   = 1'b1;
        r_kind = KIND_EXEC;
        r_job  = cur;
        r_tat  = tat_s[TimeW-1:0];
        r_wait = wait_s[TimeW-1:0];
        r_stat = stat_s[SumW-1:0];
        r_swt  = swt_s[SumW-1:0];
        r_done = done_s[DoneW-1:0];
        r_last = drn_last;
      end
      default: begin
      end
    endcase
    load = emit && (!o_valid || results.ready);
  end

  // Queue RAM: one write and one registered read a cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_data <= mem[raddr];
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      occ     <= '0;
      o_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_ADD_WR) begin
        occ <= occ + CntW'(1);
      end else if (state == S_DRN_EMIT && load && drn_last) begin
        occ <= '0;
      end
      if (load) begin
        o_valid <= 1'b1;
      end else if (results.ready) begin
        o_valid <= 1'b0;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      nj.id    <= jobs.job_id;
      nj.burst <= jobs.burst_ms;
      nj.prio  <= jobs.prio_level;
      pos      <= occ[AddrW-1:0];
      idx      <= '0;
      tat      <= '0;
      tat_prev <= '0;
      stat     <= '0;
      swt      <= '0;
      if (jobs.op == OP_ADD) begin
        res_kind <= (occ >= CntW'(QueueDepth)) ? KIND_DROPPED : KIND_ADDED;
      end else begin
        res_kind <= KIND_EMPTY;
      end
    end
    if (state == S_ADD_CMP && shift_down) begin
      pos <= pos - AddrW'(1);
    end
    if (state == S_DRN_CALC) begin
      cur      <= rd_data;
      tat_prev <= tat;
      tat      <= tat + TatW'(rd_data.burst);
    end
    if (state == S_DRN_EMIT && load) begin
      stat <= stat_sum;
      swt  <= swt_sum;
      idx  <= idx + AddrW'(1);
    end
    if (load) begin
      o_kind <= r_kind;
      o_job  <= r_job;
      o_tat  <= r_tat;
      o_wait <= r_wait;
      o_stat <= r_stat;
      o_swt  <= r_swt;
      o_done <= r_done;
      o_last <= r_last;
    end
  end

  assign jobs.ready             = in_ready;
  assign results.valid          = o_valid;
  assign results.kind           = o_kind;
  assign results.out_id         = o_job.id;
  assign results.out_burst      = o_job.burst;
  assign results.out_prio       = o_job.prio;
  assign results.turnaround     = o_tat;
  assign results.waiting        = o_wait;
  assign results.sum_turnaround = o_stat;
  assign results.sum_waiting    = o_swt;
  assign results.jobs_done      = o_done;
  assign results.last           = o_last;

`ifndef SYNTHESIS
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= CntW'(QueueDepth))
    else $error("occupancy above queue depth");

  a_occ_step: assert property (@(posedge clk) disable iff (rst)
    (occ != $past(occ)) |-> (occ == $past(occ) + CntW'(1) || occ == '0))
    else $error("occupancy moved other than by one insert or a full drain");

  a_ram_write: assert property (@(posedge clk) disable iff (rst)
    we |-> (state == S_ADD_CMP || state == S_ADD_WR))
    else $error("queue RAM written outside an insert");

  a_drn_index: assert property (@(posedge clk) disable iff (rst)
    (state == S_DRN_RD) |-> (CntW'(idx) < occ))
    else $error("drain reads past the occupied slots");

  a_drain_clears: assert property (@(posedge clk) disable iff (rst)
    (state == S_DRN_EMIT && load && drn_last) |=> (occ == '0 && state == S_IDLE))
    else $error("queue not emptied after final drain result");
`endif

endmodule

// File: tb/nps_sched_tb_pkg.sv
// Scoreboard for the priority scheduler: sorted ready-queue predictor and result checker.
package nps_sched_tb_pkg;
  import nps_pkg::*;

  typedef struct packed {
    kind_t             kind;
    logic [IdW-1:0]    id;
    logic [BurstW-1:0] burst;
    logic [PrioW-1:0]  prio;
    logic [TimeW-1:0]  tat;
    logic [TimeW-1:0]  wait_t;
    logic [SumW-1:0]   sum_tat;
    logic [SumW-1:0]   sum_wait;
    logic [DoneW-1:0]  done;
    logic              last;
  } sched_res_t;

  class sched_scoreboard;
    int unsigned depth;
    job_t        ready_q[$];
    sched_res_t  due_results[$];
    int unsigned fails;

    function new(int unsigned queue_depth);
      depth = queue_depth;
      fails = 0;
    endfunction

    function logic [31:0] clip(longint unsigned v, logic [31:0] lim);
      return (v > lim) ? lim : v[31:0];
    endfunction

    // Predict the results of one accepted job item.
    function void note_job_item(logic op, logic [IdW-1:0] id, logic [BurstW-1:0] burst,
                                logic [PrioW-1:0] prio);
      sched_res_t        r;
      job_t              nj;
      int unsigned       pos;
      longint unsigned   tat, wt, st, sw;
      r = '0;
      tat = 0;
      st = 0;
      sw = 0;
      if (op == OP_ADD) begin
        r.id = id;
        r.burst = burst;
        r.prio = prio;
        r.last = 1'b1;
        if (ready_q.size() >= depth) begin
          r.kind = KIND_DROPPED;
        end else begin
          // new job lands behind every queued job of equal or higher priority
          pos = ready_q.size();
          while (pos > 0 && ready_q[pos-1].prio < prio) pos--;
          nj.id = id;
          nj.burst = burst;
          nj.prio = prio;
          ready_q.insert(pos, nj);
          r.kind = KIND_ADDED;
        end
        due_results.push_back(r);
      end else if (ready_q.size() == 0) begin
        r.kind = KIND_EMPTY;
        r.last = 1'b1;
        due_results.push_back(r);
      end else begin
        foreach (ready_q[k]) begin
          tat += ready_q[k].burst;
          wt = tat - ready_q[k].burst;
          st += tat;
          sw += wt;
          r.kind = KIND_EXEC;
          r.id = ready_q[k].id;
          r.burst = ready_q[k].burst;
          r.prio = ready_q[k].prio;
          r.tat = clip(tat, TimeMax);
          r.wait_t = clip(wt, TimeMax);
          r.sum_tat = clip(st, SumMax);
          r.sum_wait = clip(sw, SumMax);
          r.done = clip(k + 1, DoneMax);
          r.last = (k == ready_q.size() - 1);
          due_results.push_back(r);
        end
        ready_q.delete();
      end
    endfunction

    function void cmp(string field, logic [31:0] want_v, logic [31:0] got_v);
      if (got_v !== want_v) begin
        $error("%s: expected %0h, got %0h", field, want_v, got_v);
        fails++;
      end
    endfunction

    // Compare one result transfer with the oldest prediction.
    function void check_result(sched_res_t got);
      sched_res_t want;
      if (due_results.size() == 0) begin
        $error("result with nothing predicted: kind %0d id %0h", got.kind, got.id);
        fails++;
        return;
      end
      want = due_results.pop_front();
      cmp("kind", want.kind, got.kind);
      cmp("out_id", want.id, got.id);
      cmp("out_burst", want.burst, got.burst);
      cmp("out_prio", want.prio, got.prio);
      cmp("turnaround", want.tat, got.tat);
      cmp("waiting", want.wait_t, got.wait_t);
      cmp("sum_turnaround", want.sum_tat, got.sum_tat);
      cmp("sum_waiting", want.sum_wait, got.sum_wait);
      cmp("jobs_done", want.done, got.done);
      cmp("last", want.last, got.last);
    endfunction

    function int unsigned pending();
      return due_results.size();
    endfunction
  endclass

endpackage

// File: tb/nonpreemptive_priority_scheduler_unit_test.sv
// Self-checking testbench for the non-preemptive priority scheduler unit.
module nonpreemptive_priority_scheduler_unit_test;
  import nps_pkg::*;
  import nps_sched_tb_pkg::*;

  logic clk;
  logic rst;

  // Idle and stall rates in percent; changed per phase of the run.
  int unsigned gap_pct;
  int unsigned stall_pct;

  nps_job_if jobs_ch ();
  nps_res_if res_ch ();

  sched_scoreboard sb = new(DefQueueDepth);

  nonpreemptive_priority_scheduler_unit uut (
    .clk     (clk),
    .rst     (rst),
    .jobs    (jobs_ch),
    .results (res_ch)
  );

  always #10 clk = ~clk;

  // Receiver: ready redrawn every falling edge. With stall_pct at zero it
  // stays high, so the drain runs at full rate.
  always @(negedge clk) begin
    res_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  // Result monitor: a transfer happens on a rising edge with valid and ready
  // both high. Sampled in the active region, so pre-edge values are seen.
  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready) begin
      sb.check_result('{kind: kind_t'(res_ch.kind), id: res_ch.out_id,
                        burst: res_ch.out_burst, prio: res_ch.out_prio,
                        tat: res_ch.turnaround, wait_t: res_ch.waiting,
                        sum_tat: res_ch.sum_turnaround, sum_wait: res_ch.sum_waiting,
                        done: res_ch.jobs_done, last: res_ch.last});
    end
  end

  // Offer one job item. Called at a falling edge, returns at a falling edge.
  // Valid is left high on return; the next call either keeps it high for a
  // back-to-back transfer or drops it for an idle gap, never both in one step.
  task automatic send_job(input logic op, input logic [IdW-1:0] id,
                          input logic [BurstW-1:0] burst, input logic [PrioW-1:0] prio);
    while ($urandom_range(99) < gap_pct) begin
      jobs_ch.valid <= 1'b0;
      @(negedge clk);
    end
    jobs_ch.valid      <= 1'b1;
    jobs_ch.op         <= op;
    jobs_ch.job_id     <= id;
    jobs_ch.burst_ms   <= burst;
    jobs_ch.prio_level <= prio;
    @(posedge clk);
    while (!jobs_ch.ready) @(posedge clk);
    sb.note_job_item(op, id, burst, prio);
    @(negedge clk);
  endtask

  // Hold the sender off until every predicted result has been transferred.
  task automatic drain_wait();
    jobs_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    int unsigned       phase_items;
    int unsigned       n_adds;
    int unsigned       pick;
    bit                narrow;
    logic [BurstW-1:0] burst;
    logic [PrioW-1:0]  prio;

    clk = 1'b0;
    rst = 1'b1;
    gap_pct = 0;
    stall_pct = 0;
    jobs_ch.valid = 1'b0;
    jobs_ch.op = OP_ADD;
    jobs_ch.job_id = '0;
    jobs_ch.burst_ms = '0;
    jobs_ch.prio_level = '0;
    res_ch.ready = 1'b0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: empty start, field extremes, ties at both ends and in the
    // middle, a full queue dropping an add, a full drain, then empty again.
    send_job(OP_START, 16'hFFFF, 16'hFFFF, 8'hFF);
    send_job(OP_ADD, 16'h0000, 16'h0000, 8'h00);
    send_job(OP_ADD, 16'hFFFF, 16'hFFFF, 8'hFF);
    send_job(OP_ADD, 16'h1234, 16'h0064, 8'h80);
    send_job(OP_ADD, 16'h1235, 16'h0001, 8'h80);   // ties with the one before
    send_job(OP_ADD, 16'h0001, 16'hFFFF, 8'h00);   // tie at the bottom
    send_job(OP_ADD, 16'hFFFE, 16'h8000, 8'hFF);   // tie at the top
    for (int i = 6; i < 16; i++) begin
      send_job(OP_ADD, 16'(16'hA000 + i), 16'hFFFF, 8'(i * 23));
    end
    send_job(OP_ADD, 16'h5A5A, 16'hA5A5, 8'hFF);   // queue full: dropped
    send_job(OP_START, 16'h0000, 16'h0000, 8'h00);  // sixteen-job drain, large totals
    send_job(OP_START, 16'h0F0F, 16'hF0F0, 8'h5A);  // queue cleared by the drain
    drain_wait();

    // Random: batches of adds closed by a start. Some batches overfill the
    // queue, some are empty, a third use a narrow priority range for ties.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 48; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 48; end
        default: begin gap_pct = 6; stall_pct = 6; end
      endcase
      phase_items = 0;
      while (phase_items < 35) begin
        pick = $urandom_range(99);
        if (pick < 8) begin
          n_adds = 0;
        end else if (pick < 18) begin
          n_adds = $urandom_range(20, 17);
        end else begin
          n_adds = $urandom_range(16, 1);
        end
        narrow = ($urandom_range(2) == 0);
        for (int j = 0; j < n_adds; j++) begin
          prio = narrow ? 8'($urandom_range(3)) : 8'($urandom);
          case ($urandom_range(7))
            0: begin burst = '0; end
            1: begin burst = '1; end
            default: begin burst = 16'($urandom); end
          endcase
          send_job(OP_ADD, 16'($urandom), burst, prio);
        end
        send_job(OP_START, 16'($urandom), 16'($urandom), 8'($urandom));
        phase_items += n_adds + 1;
      end
      drain_wait();
    end

    // Nothing outstanding; allow a short settle for stray transfers.
    repeat (20) @(posedge clk);
    if (sb.fails == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog, several times the slowest legal run.
  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
